>>> design/cwq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cwq_pkg;

    localparam int QUEUE_SLOTS_DEF = 16;
    localparam int ID_BITS_DEF     = 8;

    localparam int ACTION_W = 3;
    localparam int TID_W    = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 4;
    localparam int OUT_W    = STATUS_W + 1 + TID_W + 1 + COUNT_W;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WAIT      = 3'd0,
        ACT_SIGNAL    = 3'd1,
        ACT_BROADCAST = 3'd2,
        ACT_CANCEL    = 3'd3,
        ACT_DESTROY   = 3'd4
    } act_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_WAITERS = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SIG_WAIT,
        S_BC_EMIT,
        S_CAN_CMP,
        S_CAN_SHIFT,
        S_FINAL
    } state_t;

    typedef enum logic [1:0] {
        RD_HEAD,
        RD_NEXT,
        RD_NEXT2
    } rd_sel_t;

    // controller -> datapath
    typedef struct packed {
        logic    in_ready;
        logic    load_res;
        status_t res_status;
        logic    set_woken;
        logic    set_removed;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    scan_adv;
        logic    wr_tail;
        logic    wr_shift;
        logic    head_inc;
        logic    tail_dec;
        logic    clear_ptrs;
        logic    emit_final;
        logic    emit_bcast;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        act_t action;
        logic full;
        logic empty;
        logic id_match;
        logic next_is_tail;
        logic next2_is_tail;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

>>> design/cwq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module cwq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> design/cwq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module cwq_ctrl
    import cwq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (sts.action)
                    ACT_SIGNAL:    state_next = sts.empty ? S_FINAL : S_SIG_WAIT;
                    ACT_BROADCAST: state_next = sts.empty ? S_FINAL : S_BC_EMIT;
                    ACT_CANCEL:    state_next = sts.empty ? S_FINAL : S_CAN_CMP;
                    default:       state_next = S_FINAL;
                endcase
            end
            S_SIG_WAIT:
            begin
                state_next = S_FINAL;
            end
            S_BC_EMIT:
            begin
                if (sts.out_free && sts.next_is_tail)
                begin
                    state_next = S_IDLE;
                end
            end
            S_CAN_CMP:
            begin
                if (sts.next_is_tail)
                begin
                    state_next = S_FINAL;
                end
                else if (sts.id_match)
                begin
                    state_next = S_CAN_SHIFT;
                end
            end
            S_CAN_SHIFT:
            begin
                if (sts.next2_is_tail)
                begin
                    state_next = S_FINAL;
                end
            end
            S_FINAL:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.res_status = ST_OK;
        cmd.rd_sel     = RD_HEAD;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
            end
            S_DISPATCH:
            begin
                cmd.load_res = 1'b1;
                case (sts.action)
                    ACT_WAIT:
                    begin
                        if (sts.full)
                        begin
                            cmd.res_status = ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_tail = 1'b1;
                        end
                    end
                    ACT_SIGNAL:
                    begin
                        if (sts.empty)
                        begin
                            cmd.res_status = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.rd_en = 1'b1;
                        end
                    end
                    ACT_BROADCAST:
                    begin
                        cmd.rd_en      = !sts.empty;
                        cmd.clear_ptrs = sts.empty;
                    end
                    ACT_CANCEL:
                    begin
                        cmd.rd_en = !sts.empty;
                    end
                    ACT_DESTROY:
                    begin
                        if (sts.empty)
                        begin
                            cmd.clear_ptrs = 1'b1;
                        end
                        else
                        begin
                            cmd.res_status = ST_WAITERS;
                        end
                    end
                    default:
                    begin
                        cmd.res_status = ST_OK;
                    end
                endcase
            end
            S_SIG_WAIT:
            begin
                cmd.head_inc  = 1'b1;
                cmd.set_woken = 1'b1;
            end
            S_BC_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_bcast = 1'b1;
                    if (sts.next_is_tail)
                    begin
                        cmd.clear_ptrs = 1'b1;
                    end
                    else
                    begin
                        cmd.rd_en    = 1'b1;
                        cmd.rd_sel   = RD_NEXT;
                        cmd.scan_adv = 1'b1;
                    end
                end
            end
            S_CAN_CMP:
            begin
                if (sts.id_match)
                begin
                    cmd.set_removed = 1'b1;
                    if (sts.next_is_tail)
                    begin
                        cmd.tail_dec = 1'b1;
                    end
                    else
                    begin
                        // fetch the entry after the match, scan stays on the hole
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_NEXT;
                    end
                end
                else if (!sts.next_is_tail)
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.rd_sel   = RD_NEXT;
                    cmd.scan_adv = 1'b1;
                end
            end
            S_CAN_SHIFT:
            begin
                cmd.wr_shift = 1'b1;
                cmd.scan_adv = 1'b1;
                if (sts.next2_is_tail)
                begin
                    cmd.tail_dec = 1'b1;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_NEXT2;
                end
            end
            S_FINAL:
            begin
                cmd.emit_final = sts.out_free;
            end
            default:
            begin
                cmd.in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/cwq_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module cwq_dp
    import cwq_pkg::*;
#(
    parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    input  wire logic [TID_W-1:0]    s_tdata,
    input  wire logic [ACTION_W-1:0] s_tuser,
    input  wire logic                m_tready,
    input  wire cmd_t                cmd,
    output sts_t                     sts,
    output logic                     m_tvalid,
    output logic [OUT_W-1:0]         m_tdata,
    output logic                     m_tlast
);

    localparam int PTR_W = $clog2(QUEUE_SLOTS);

    function automatic logic [PTR_W-1:0] slot_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(QUEUE_SLOTS - 1))
        begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] slot_dec(input logic [PTR_W-1:0] p);
        if (p == '0)
        begin
            return PTR_W'(QUEUE_SLOTS - 1);
        end
        return p - 1'b1;
    endfunction

    logic [PTR_W-1:0]    head_reg, head_next;
    logic [PTR_W-1:0]    tail_reg, tail_next;
    logic [PTR_W-1:0]    scan_reg, scan_next;
    logic [ACTION_W-1:0] act_reg;
    logic [TID_W-1:0]    tid_reg;
    status_t             res_status_reg;
    logic                res_woken_reg;
    logic                res_removed_reg;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] o_status_reg;
    logic                o_wv_reg;
    logic [TID_W-1:0]    o_wid_reg;
    logic                o_rem_reg;
    logic [COUNT_W-1:0]  o_cnt_reg;
    logic                o_last_reg;

    logic [PTR_W-1:0]    scan_p1, scan_p2;
    logic [PTR_W:0]      total;
    logic                ram_wr_en;
    logic [PTR_W-1:0]    ram_wr_addr;
    logic [ID_BITS-1:0]  ram_wr_data;
    logic [PTR_W-1:0]    ram_rd_addr;
    logic [ID_BITS-1:0]  ram_rd_data;
    logic                accept;

    assign accept  = s_tvalid && cmd.in_ready;
    assign scan_p1 = slot_inc(scan_reg);
    assign scan_p2 = slot_inc(scan_p1);
    assign total   = (tail_reg >= head_reg)
                   ? {1'b0, tail_reg} - {1'b0, head_reg}
                   : {1'b0, tail_reg} + (PTR_W+1)'(QUEUE_SLOTS) - {1'b0, head_reg};

    assign sts.action        = act_t'(act_reg);
    assign sts.full          = (slot_inc(tail_reg) == head_reg);
    assign sts.empty         = (head_reg == tail_reg);
    assign sts.id_match      = (ram_rd_data == ID_BITS'(tid_reg));
    assign sts.next_is_tail  = (scan_p1 == tail_reg);
    assign sts.next2_is_tail = (scan_p2 == tail_reg);
    assign sts.out_free      = !out_valid_reg || m_tready;

    // ring write: enqueue at tail, or close the gap during cancel
    assign ram_wr_en   = cmd.wr_tail || cmd.wr_shift;
    assign ram_wr_addr = cmd.wr_shift ? scan_reg : tail_reg;
    assign ram_wr_data = cmd.wr_shift ? ram_rd_data : ID_BITS'(tid_reg);

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_HEAD:  ram_rd_addr = head_reg;
            RD_NEXT:  ram_rd_addr = scan_p1;
            RD_NEXT2: ram_rd_addr = scan_p2;
            default:  ram_rd_addr = head_reg;
        endcase
    end

    cwq_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (QUEUE_SLOTS)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        scan_next = scan_reg;
        if (cmd.head_inc)
        begin
            head_next = slot_inc(head_reg);
        end
        if (cmd.wr_tail)
        begin
            tail_next = slot_inc(tail_reg);
        end
        if (cmd.tail_dec)
        begin
            tail_next = slot_dec(tail_reg);
        end
        if (cmd.clear_ptrs)
        begin
            head_next = '0;
            tail_next = '0;
        end
        if (cmd.rd_en && cmd.rd_sel == RD_HEAD)
        begin
            scan_next = head_reg;
        end
        else if (cmd.scan_adv)
        begin
            scan_next = scan_p1;
        end
    end

    assign out_valid_next = (cmd.emit_final || cmd.emit_bcast) ? 1'b1
                          : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= s_tuser;
            tid_reg <= s_tdata;
        end
        if (cmd.load_res)
        begin
            res_status_reg  <= cmd.res_status;
            res_woken_reg   <= 1'b0;
            res_removed_reg <= 1'b0;
        end
        if (cmd.set_woken)
        begin
            res_woken_reg <= 1'b1;
        end
        if (cmd.set_removed)
        begin
            res_removed_reg <= 1'b1;
        end
        if (cmd.emit_final)
        begin
            o_status_reg <= res_status_reg;
            o_wv_reg     <= res_woken_reg;
            o_wid_reg    <= res_woken_reg ? TID_W'(ram_rd_data) : '0;
            o_rem_reg    <= res_removed_reg;
            o_cnt_reg    <= COUNT_W'(total);
            o_last_reg   <= 1'b1;
        end
        else if (cmd.emit_bcast)
        begin
            o_status_reg <= ST_OK;
            o_wv_reg     <= 1'b1;
            o_wid_reg    <= TID_W'(ram_rd_data);
            o_rem_reg    <= 1'b0;
            o_cnt_reg    <= '0;
            o_last_reg   <= sts.next_is_tail;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {o_cnt_reg, o_rem_reg, o_wid_reg, o_wv_reg, o_status_reg};
    assign m_tlast  = o_last_reg;

endmodule

`default_nettype wire

>>> design/condition_wait_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: action; tdata: thread_id
// m_*       out  m_tvalid/m_tready  tdata: status, woken_valid, woken_id,
//                                   removed, waiter_count; tlast: last
//
// One action at a time. Broadcast does one ring read per item. Cancel
// makes the compare walk up to the match, then shifts each later entry down
// by one slot (one ring read and one ring write per shift). Reset clears
// head/tail and the output valid; ring contents are not cleared. A stalled
// m_tready holds the sequencer at the next result item.

module condition_wait_queue
    import cwq_pkg::*;
#(
    parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [TID_W-1:0]    s_tdata,   // thread_id
    input  wire logic [ACTION_W-1:0] s_tuser,   // action
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // status[1:0], woken_valid[2], woken_id[10:3], removed[11], waiter_count[15:12]
    output logic [OUT_W-1:0]         m_tdata,
    output logic                     m_tlast
);

    cmd_t cmd;
    sts_t sts;

    cwq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .sts      (sts),
        .cmd      (cmd)
    );

    cwq_dp #(
        .QUEUE_SLOTS (QUEUE_SLOTS),
        .ID_BITS     (ID_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    assign s_tready = cmd.in_ready;

endmodule

`default_nettype wire
